### design/dpo_pkg.sv
// Shared constants, command codes and control structs for the dust pulse occupancy block.
package dpo_pkg;

    localparam int NUM_SAMPLES = 5;

    localparam int NOW_W   = 32;
    localparam int US_W    = 20;
    localparam int WIN_W   = 20;
    localparam int OCC_W   = 32;
    localparam int RATIO_W = 23;
    localparam int R2_W    = 30;
    localparam int R3_W    = 37;
    localparam int MUL_W   = R2_W + RATIO_W;
    localparam int CONC_W  = 43;
    localparam int NUM_W   = 52;
    localparam int DEN_W   = 24;
    localparam int MASS_W  = 24;
    localparam int CNT_W   = $clog2(NUM_SAMPLES + 1);
    localparam int IDX_W   = $clog2(NUM_SAMPLES);
    localparam int PHASE_W = $clog2(NUM_SAMPLES + 1);
    localparam int MEAN_N  = NUM_SAMPLES - 2;
    localparam int SUM_W   = MASS_W + $clog2(MEAN_N + 1);
    localparam int DIVC_W  = $clog2(NUM_W + 1);

    // trimmed mean: multiply by ceil(2^MEAN_K / MEAN_N) and drop MEAN_K bits
    localparam int MEAN_K   = SUM_W + $clog2(MEAN_N);
    localparam int MEAN_RW  = SUM_W + 2;
    localparam int MEAN_P_W = SUM_W + MEAN_RW;

    // mass: 2560000 = 4096 * 625; shift out 12 bits, then reciprocal of 625 in two halves
    localparam int MASS_SHIFT   = 12;
    localparam int MASS_Y_W     = 34;
    localparam int MASS_HALF_W  = 17;
    localparam int MASS_RECIP_W = 33;
    localparam int PART_W       = MASS_HALF_W + MASS_RECIP_W;
    localparam int ACC_W        = PART_W + MASS_HALF_W;
    localparam int MASS_K       = 42;

    localparam logic [WIN_W-1:0]   WIN_RESET   = 20'd30000;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 23'h7FFFFF;
    localparam logic [MASS_W-1:0]  MASS_MAX    = 24'hFFFFFF;
    localparam logic [DEN_W-1:0]   RATIO_SCALE = 24'd10;
    localparam logic [NUM_W-1:0]   MASS_OFS    = 52'd2392064000;
    localparam logic [NUM_W-1:0]   MASS_SAT    = 52'd42949672960000;
    localparam logic [NUM_W-1:0]   K_DIFF      = 52'd182;
    localparam logic [CONC_W-1:0]  K_CUBE      = 43'd11;
    localparam logic [CONC_W-1:0]  K_SQ        = 43'd38;
    localparam logic [CONC_W-1:0]  K_LIN       = 43'd5200;
    localparam logic [CONC_W-1:0]  C_OFS       = 43'd406323;
    localparam logic [MASS_RECIP_W-1:0] MASS_RECIP = 33'd7036874418;
    localparam logic [MEAN_RW-1:0] MEAN_RECIP =
        MEAN_RW'(((64'd1 << MEAN_K) + 64'(MEAN_N) - 64'd1) / 64'(MEAN_N));

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_RATIO_GO   = 4'd2;
    localparam logic [3:0] OP_RATIO_TAKE = 4'd3;
    localparam logic [3:0] OP_SQ         = 4'd4;
    localparam logic [3:0] OP_CUBE       = 4'd5;
    localparam logic [3:0] OP_POLY_A     = 4'd6;
    localparam logic [3:0] OP_POLY_B     = 4'd7;
    localparam logic [3:0] OP_DIFF       = 4'd8;
    localparam logic [3:0] OP_MASS_GO    = 4'd9;
    localparam logic [3:0] OP_MASS_TAKE  = 4'd10;
    localparam logic [3:0] OP_SORT       = 4'd11;
    localparam logic [3:0] OP_MEAN_TAKE  = 4'd13;
    localparam logic [3:0] OP_CLEAR      = 4'd14;
    localparam logic [3:0] OP_OUT        = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       chan;
        logic       phase;
    } cmd_t;

    typedef struct packed {
        logic closed;
        logic div_rdy;
        logic positive;
        logic full;
    } stat_t;

endpackage

### design/dpo_div.sv
// Restoring divider, one quotient bit per cycle.
module dpo_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dpo_pkg::NUM_W-1:0] num,
    input  logic [dpo_pkg::DEN_W-1:0] den,
    output logic                      rdy,
    output logic [dpo_pkg::NUM_W-1:0] quo
);
    import dpo_pkg::*;

    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W:0]    trial;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign rdy   = (cnt_reg == '0);
    assign quo   = quo_reg;

    always_comb begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        if (start) begin
            cnt_next = DIVC_W'(NUM_W);
            num_next = num;
            den_next = den;
            rem_next = '0;
            quo_next = '0;
        end else if (!rdy) begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

### design/dpo_dpath.sv
// Datapath: accumulators, ratio, cubic curve, mass, sample store, sort and mean.
module dpo_dpath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dpo_pkg::cmd_t             cmd,
    output dpo_pkg::stat_t            stat,
    input  logic [dpo_pkg::WIN_W-1:0] win,
    input  logic [dpo_pkg::NOW_W-1:0] now_ms,
    input  logic [dpo_pkg::US_W-1:0]  low_small_us,
    input  logic [dpo_pkg::US_W-1:0]  low_large_us,
    output logic [31:0]               out_data
);
    import dpo_pkg::*;

    logic [NOW_W-1:0]   now_reg, start_reg;
    logic [OCC_W-1:0]   occ_s_reg, occ_l_reg;
    logic [RATIO_W-1:0] r_reg;
    logic [R2_W-1:0]    r2_reg;
    logic [R3_W-1:0]    r3_reg;
    logic [CONC_W-1:0]  t_reg, cs_reg, cl_reg;
    logic [NUM_W-1:0]   mnum_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [MASS_W-1:0]  store_reg [NUM_SAMPLES];
    logic [MASS_W-1:0]  store_next [NUM_SAMPLES];
    logic [CNT_W-1:0]   cnt_reg;
    logic [MASS_W-1:0]  cur_reg;
    logic [31:0]        out_reg;

    logic [WIN_W-1:0]       win_eff;
    logic [DEN_W-1:0]       ratio_den;
    logic                   div_start, div_rdy;
    logic [NUM_W-1:0]       div_num, div_quo;
    logic [R2_W-1:0]        mul_a;
    logic [MUL_W-1:0]       mul_p;
    logic [SUM_W-1:0]       mid_sum;
    logic [MEAN_P_W-1:0]    mean_p;
    logic [MASS_HALF_W-1:0] y_part;
    logic [PART_W-1:0]      part_p;
    logic [MASS_W-1:0]      mass_q;
    logic [CONC_W-1:0]      conc, diff;
    logic [OCC_W-1:0]       occ_sel;

    assign win_eff   = (win == '0) ? WIN_W'(1) : win;
    assign ratio_den = DEN_W'(win_eff) * RATIO_SCALE;
    assign occ_sel   = cmd.chan ? occ_l_reg : occ_s_reg;

    always_comb begin
        mid_sum = '0;
        for (int i = 1; i < NUM_SAMPLES - 1; i++) begin
            mid_sum = mid_sum + SUM_W'(store_reg[i]);
        end
    end

    assign mean_p = MEAN_P_W'(mid_sum) * MEAN_P_W'(MEAN_RECIP);

    assign div_start = (cmd.op == OP_RATIO_GO);
    assign div_num   = {4'b0, occ_sel, 16'b0};

    dpo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (ratio_den),
        .rdy     (div_rdy),
        .quo     (div_quo)
    );

    // shared multiplier: r*r, then r2*r
    assign mul_a = (cmd.op == OP_CUBE) ? r2_reg : R2_W'(r_reg);
    assign mul_p = MUL_W'(mul_a) * MUL_W'(r_reg);

    // reciprocal of 625 on the shifted numerator: low half on phase 0, high half on phase 1
    assign y_part = cmd.phase ? mnum_reg[MASS_SHIFT+MASS_Y_W-1:MASS_SHIFT+MASS_HALF_W]
                              : mnum_reg[MASS_SHIFT+MASS_HALF_W-1:MASS_SHIFT];
    assign part_p = PART_W'(y_part) * PART_W'(MASS_RECIP);
    assign mass_q = (mnum_reg >= MASS_SAT) ? MASS_MAX : acc_reg[MASS_K+MASS_W-1:MASS_K];

    assign conc = t_reg + C_OFS - CONC_W'(r2_reg) * K_SQ;
    assign diff = cl_reg - cs_reg;

    // odd-even transposition step
    always_comb begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            store_next[i] = store_reg[i];
        end
        for (int i = 0; i < NUM_SAMPLES - 1; i++) begin
            if ((i % 2) == int'(cmd.phase) && store_reg[i] > store_reg[i+1]) begin
                store_next[i]   = store_reg[i+1];
                store_next[i+1] = store_reg[i];
            end
        end
    end

    always_comb begin
        stat.closed   = (now_reg - start_reg) > NOW_W'(win);
        stat.div_rdy  = div_rdy;
        stat.positive = cl_reg > cs_reg;
        stat.full     = (cnt_reg == CNT_W'(NUM_SAMPLES));
    end

    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_s_reg <= '0;
            occ_l_reg <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
        end else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    occ_s_reg <= occ_s_reg + OCC_W'(low_small_us);
                    occ_l_reg <= occ_l_reg + OCC_W'(low_large_us);
                end
                OP_MASS_TAKE: begin
                    cur_reg <= mass_q;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                OP_MEAN_TAKE: begin
                    cur_reg <= mean_p[MEAN_K+MASS_W-1:MEAN_K];
                    cnt_reg <= '0;
                end
                OP_CLEAR: begin
                    occ_s_reg <= '0;
                    occ_l_reg <= '0;
                    start_reg <= now_reg;
                end
                default: begin
                end
            endcase
        end
        unique case (cmd.op)
            OP_LOAD:       now_reg <= now_ms;
            OP_RATIO_TAKE: r_reg <= (div_quo[NUM_W-1:RATIO_W] != '0) ? RATIO_MAX
                                                                    : div_quo[RATIO_W-1:0];
            OP_SQ:         r2_reg <= mul_p[R2_W+15:16];
            OP_CUBE:       r3_reg <= mul_p[MUL_W-1:16];
            OP_POLY_A:     t_reg <= CONC_W'(r3_reg) * K_CUBE + CONC_W'(r_reg) * K_LIN;
            OP_POLY_B: begin
                if (cmd.chan) begin
                    cl_reg <= conc;
                end else begin
                    cs_reg <= conc;
                end
            end
            OP_DIFF:       mnum_reg <= NUM_W'(diff) * K_DIFF + MASS_OFS;
            OP_MASS_GO: begin
                if (cmd.phase) begin
                    acc_reg <= acc_reg + {part_p, MASS_HALF_W'(0)};
                end else begin
                    acc_reg <= ACC_W'(part_p);
                end
            end
            OP_MASS_TAKE: begin
                store_reg[cnt_reg[IDX_W-1:0]] <= mass_q;
            end
            OP_SORT: begin
                for (int i = 0; i < NUM_SAMPLES; i++) begin
                    store_reg[i] <= store_next[i];
                end
            end
            OP_OUT:        out_reg <= {cur_reg, cur_reg[15:8]};
            default: begin
            end
        endcase
    end

endmodule

### design/dpo_ctrl.sv
// Sequencer for one request: window test, two curves, mass, sort, mean, result hand-off.
module dpo_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [1:0]     m_tuser,
    output dpo_pkg::cmd_t  cmd,
    input  dpo_pkg::stat_t stat
);
    import dpo_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_RGO   = 5'd2;
    localparam logic [4:0] S_RWAIT = 5'd3;
    localparam logic [4:0] S_SQ    = 5'd4;
    localparam logic [4:0] S_CUBE  = 5'd5;
    localparam logic [4:0] S_PA    = 5'd6;
    localparam logic [4:0] S_PB    = 5'd7;
    localparam logic [4:0] S_DIFF  = 5'd8;
    localparam logic [4:0] S_MLO   = 5'd9;
    localparam logic [4:0] S_MHI   = 5'd10;
    localparam logic [4:0] S_TEST  = 5'd11;
    localparam logic [4:0] S_SORT  = 5'd12;
    localparam logic [4:0] S_MTAKE = 5'd13;
    localparam logic [4:0] S_MEAN  = 5'd14;
    localparam logic [4:0] S_CLR   = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0]         state_reg, state_next;
    logic               chan_reg, chan_next;
    logic [PHASE_W-1:0] ph_reg, ph_next;
    logic               closed_reg, closed_next;
    logic               ready_reg, ready_next;
    logic               valid_reg, valid_next;
    logic [1:0]         user_reg, user_next;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = valid_reg;
    assign m_tuser   = user_reg;

    always_comb begin
        state_next  = state_reg;
        chan_next   = chan_reg;
        ph_next     = ph_reg;
        closed_next = closed_reg;
        ready_next  = ready_reg;
        valid_next  = valid_reg;
        user_next   = user_reg;
        cmd.op      = OP_NONE;
        cmd.chan    = chan_reg;
        cmd.phase   = ph_reg[0];
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op      = OP_LOAD;
                    closed_next = 1'b0;
                    ready_next  = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                chan_next = 1'b0;
                if (stat.closed) begin
                    closed_next = 1'b1;
                    state_next  = S_RGO;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_RGO: begin
                cmd.op     = OP_RATIO_GO;
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                if (stat.div_rdy) begin
                    cmd.op     = OP_RATIO_TAKE;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                cmd.op     = OP_SQ;
                state_next = S_CUBE;
            end
            S_CUBE: begin
                cmd.op     = OP_CUBE;
                state_next = S_PA;
            end
            S_PA: begin
                cmd.op     = OP_POLY_A;
                state_next = S_PB;
            end
            S_PB: begin
                cmd.op = OP_POLY_B;
                if (!chan_reg) begin
                    chan_next  = 1'b1;
                    state_next = S_RGO;
                end else begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                if (stat.positive) begin
                    cmd.op     = OP_DIFF;
                    ph_next    = '0;
                    state_next = S_MLO;
                end else begin
                    state_next = S_CLR;
                end
            end
            S_MLO: begin
                cmd.op     = OP_MASS_GO;
                ph_next    = ph_reg + 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.op     = OP_MASS_GO;
                state_next = S_MTAKE;
            end
            S_MTAKE: begin
                cmd.op     = OP_MASS_TAKE;
                state_next = S_TEST;
            end
            S_TEST: begin
                ph_next    = '0;
                state_next = stat.full ? S_SORT : S_CLR;
            end
            S_SORT: begin
                cmd.op  = OP_SORT;
                ph_next = ph_reg + 1'b1;
                if (ph_reg == PHASE_W'(NUM_SAMPLES - 1)) begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN: begin
                cmd.op     = OP_MEAN_TAKE;
                ready_next = 1'b1;
                state_next = S_CLR;
            end
            S_CLR: begin
                cmd.op     = OP_CLEAR;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    user_next  = {ready_reg, closed_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        chan_reg   <= chan_next;
        ph_reg     <= ph_next;
        closed_reg <= closed_next;
        ready_reg  <= ready_next;
        user_reg   <= user_next;
    end

endmodule

### design/dust_pulse_occupancy_pm25.sv
// Top level: APB window register, sequencer and datapath of the dust mass estimator.
//
//  channel  | direction | handshake               | contents
//  s_       | in        | s_tvalid / s_tready     | now_ms, low_small_us, low_large_us
//  m_       | out       | m_tvalid / m_tready     | report_byte, mass_value_q8, flags
//  apb      | in        | psel, penable, pready   | sample_window_ms at byte address 0
//
// An item that leaves the window open goes from the check state straight to the output state.
// A closing item runs the 52-step serial ratio divider once per channel and stores a
// mass sample if the large curve is higher; a full store is sorted and averaged.
// Reset is synchronous on aresetn; the window length returns to 30000 ms.
// A new request is taken while the previous result waits; a stalled m_ side holds
// the sequencer in its last state.
module dust_pulse_occupancy_pm25 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // now_ms[31:0], low_small_us[51:32], low_large_us[71:52]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // report_byte[7:0], mass_value_q8[31:8]
    output logic [1:0]  m_tuser,   // window_closed[0], average_ready[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dpo_pkg::*;

    logic [WIN_W-1:0] win_reg;
    cmd_t             cmd;
    stat_t            stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(win_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            win_reg <= pwdata[WIN_W-1:0];
        end
    end

    dpo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    dpo_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .win          (win_reg),
        .now_ms       (s_tdata[31:0]),
        .low_small_us (s_tdata[51:32]),
        .low_large_us (s_tdata[71:52]),
        .out_data     (m_tdata)
    );

    a_ready_needs_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
        else $error("average flagged without a closed window");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the sequencer was busy");

    a_report_from_mass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[7:0] == m_tdata[23:16]))
        else $error("report byte does not match mass integer part");

endmodule
